>>> design/frame_rate_monitor_unit_assert.svh
// Assertion macros used by the frame rate monitor checker.
`ifndef FRAME_RATE_MONITOR_UNIT_ASSERT_SVH
`define FRAME_RATE_MONITOR_UNIT_ASSERT_SVH

// Clocked check, suspended while reset is asserted.
`define FRM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define FRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/frm_pkg.sv
// Shared types and constants for the frame rate monitor.
package frm_pkg;

    localparam int TIME_W   = 48;   // commit timestamp width
    localparam int FRAMES_W = 16;   // frame counter width
    localparam int WIN_W    = 24;   // window length width
    localparam int NUM_W    = FRAMES_W + WIN_W;  // dividend width
    localparam int RATE_W   = 8;
    localparam int GAP_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int unsigned DEF_IDLE_RATE = 30;
    localparam int unsigned DEF_WINDOW_US = 1000000;

    localparam logic [RATE_W-1:0] RESTORE_MARK = 8'hFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP_US    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage

>>> design/frame_rate_monitor_unit.sv
// Frame rate monitor: per-commit window bookkeeping and bit-serial rate divider.
// Steps: each accepted commit is evaluated, and when a full window closes the rate is
//   computed by a multiply, then a 40-step restoring divider, one dividend bit per cycle.
// A new transaction is accepted only once the last one is through; a
//   result held back by the receiver stalls the input until it leaves.
// Reset (synchronous, active low) restores register defaults, clears window state.
module frame_rate_monitor_unit #(
    parameter int unsigned DEFAULT_IDLE_RATE = frm_pkg::DEF_IDLE_RATE,
    parameter int unsigned WINDOW_US         = frm_pkg::DEF_WINDOW_US
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [frm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [frm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // commit event channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [frm_pkg::TIME_W-1:0]      i_time_us,
    input  logic                            i_user_input,
    input  logic                            i_idle_mode,
    // rate report channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [frm_pkg::RATE_W-1:0]      o_rate_value
);
    import frm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [WIN_W-1:0]  LP_WIN  = WIN_W'(WINDOW_US);
    localparam logic [RATE_W-1:0] LP_IDLE = RATE_W'(DEFAULT_IDLE_RATE);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic               r_enable;
    logic [RATE_W-1:0]  r_idle_rate;
    logic [RATE_W-1:0]  r_max_rate;
    logic               r_cmd_mode;
    logic [GAP_W-1:0]   r_long_gap_us;
    logic [RATE_W-1:0]  r_long_gap_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable         <= 1'b1;
            r_idle_rate      <= '0;
            r_max_rate       <= RATE_W'(60);
            r_cmd_mode       <= 1'b1;
            r_long_gap_us    <= GAP_W'(100000);
            r_long_gap_limit <= RATE_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:         r_enable         <= i_cfg_data[0];
                CFG_IDLE_RATE:      r_idle_rate      <= i_cfg_data[RATE_W-1:0];
                CFG_MAX_RATE:       r_max_rate       <= i_cfg_data[RATE_W-1:0];
                CFG_COMMAND_MODE:   r_cmd_mode       <= i_cfg_data[0];
                CFG_LONG_GAP_US:    r_long_gap_us    <= i_cfg_data[GAP_W-1:0];
                CFG_LONG_GAP_LIMIT: r_long_gap_limit <= i_cfg_data[RATE_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    // latched transaction
    logic [TIME_W-1:0]   r_time, n_time;
    logic                r_user, n_user;
    logic                r_idle, n_idle;

    // window bookkeeping
    logic [TIME_W-1:0]   r_win_start, n_win_start;
    logic [TIME_W-1:0]   r_last_commit, n_last_commit;
    logic                r_commit_seen, n_commit_seen;
    logic [FRAMES_W-1:0] r_frames, n_frames;
    logic [RATE_W-1:0]   r_gap_run, n_gap_run;
    logic [RATE_W-1:0]   r_last_rate, n_last_rate;
    logic                r_win_open, n_win_open;
    logic                r_skip, n_skip;

    // serial divider: dividend shifts out MSB first into the remainder
    logic [NUM_W-1:0]    r_num, n_num;
    logic [TIME_W-1:0]   r_rem, n_rem;
    logic [TIME_W-1:0]   r_div, n_div;
    logic [RATE_W-1:0]   r_quo, n_quo;
    logic                r_sat, n_sat;     // quotient bit lost above bit 7
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // pending result and output register
    logic [RATE_W-1:0]   r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [RATE_W-1:0]   r_out_rate, n_out_rate;

    // ---------------------------------------------------------------
    // Decision logic, evaluated on the latched transaction
    // ---------------------------------------------------------------
    logic                w_accept;
    logic                w_out_free;
    logic [RATE_W-1:0]   w_idle_val;
    logic [TIME_W-1:0]   w_ws;
    logic [TIME_W-1:0]   w_elapsed;
    logic [TIME_W-1:0]   w_gap;
    logic                w_long_gap;
    logic                w_win_done;
    logic [FRAMES_W-1:0] w_frames_inc;
    logic [RATE_W-1:0]   w_run_inc;
    logic [RATE_W-1:0]   w_rate;
    logic [TIME_W:0]     w_rem_sh;
    logic [TIME_W:0]     w_rem_sub;
    logic                w_ge;
    logic                w_emit;    // a result leaves this evaluation
    logic                w_go_div;  // window closed with a rate to compute

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_idle_val   = (r_idle_rate != '0) ? r_idle_rate : LP_IDLE;
    // a closed window reopens at this commit
    assign w_ws         = r_win_open ? r_win_start : r_time;
    assign w_elapsed    = r_time - w_ws;           // wraps modulo 2^48
    assign w_gap        = r_time - r_last_commit;
    assign w_long_gap   = r_commit_seen && (w_gap > TIME_W'(r_long_gap_us));
    assign w_win_done   = w_elapsed >= TIME_W'(WINDOW_US);
    assign w_frames_inc = (r_frames == '1) ? r_frames : r_frames + 1'b1;
    assign w_run_inc    = (r_gap_run == '1) ? r_gap_run : r_gap_run + 1'b1;
    assign w_rate       = r_sat ? RESTORE_MARK : r_quo;

    // one restoring step per cycle
    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_div};
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_comb begin
        n_time        = r_time;
        n_user        = r_user;
        n_idle        = r_idle;
        n_win_start   = r_win_start;
        n_last_commit = r_last_commit;
        n_commit_seen = r_commit_seen;
        n_frames      = r_frames;
        n_gap_run     = r_gap_run;
        n_last_rate   = r_last_rate;
        n_win_open    = r_win_open;
        n_skip        = r_skip;
        n_num         = r_num;
        n_rem         = r_rem;
        n_div         = r_div;
        n_quo         = r_quo;
        n_sat         = r_sat;
        n_cnt         = r_cnt;
        n_res         = r_res;
        w_emit        = 1'b0;
        w_go_div      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_time = i_time_us;
                    n_user = i_user_input;
                    n_idle = i_idle_mode;
                end
            end

            ST_EVAL: begin
                if (r_enable) begin
                    if (r_user) begin
                        // restore mark, then assume the maximum rate
                        w_emit      = 1'b1;
                        n_res       = RESTORE_MARK;
                        n_gap_run   = '0;
                        n_last_rate = r_max_rate;
                        n_skip      = 1'b1;
                    end else if (r_idle) begin
                        if (r_last_rate != w_idle_val) begin
                            if (r_cmd_mode) begin
                                w_emit    = 1'b1;
                                n_res     = w_idle_val;
                                n_gap_run = '0;
                            end
                            n_last_rate = w_idle_val;
                        end
                    end else begin
                        n_win_start = w_ws;
                        n_win_open  = 1'b1;
                        n_frames    = w_frames_inc;
                        if (w_long_gap) begin
                            n_gap_run = w_run_inc;
                            if (w_run_inc > r_long_gap_limit) begin
                                w_emit      = 1'b1;
                                n_res       = w_idle_val;
                                n_gap_run   = '0;
                                n_last_rate = w_idle_val;
                            end
                        end else begin
                            if (r_commit_seen) begin
                                n_gap_run = '0;
                            end
                            if (w_win_done) begin
                                if (r_skip) begin
                                    n_skip = 1'b0;
                                end else begin
                                    w_go_div = 1'b1;
                                    n_div    = w_elapsed;
                                end
                            end else begin
                                n_last_commit = r_time;
                                n_commit_seen = 1'b1;
                            end
                        end
                    end

                    // close the window unless the commit only extends it
                    if (r_user || r_idle || w_long_gap || (w_win_done && r_skip)) begin
                        n_win_start   = r_time;
                        n_last_commit = r_time;
                        n_commit_seen = 1'b1;
                        n_frames      = '0;
                        n_win_open    = 1'b0;
                    end
                end
            end

            ST_MUL: begin
                n_num = NUM_W'(r_frames) * NUM_W'(LP_WIN);
                n_rem = '0;
                n_quo = '0;
                n_sat = 1'b0;
                n_cnt = CNT_W'(NUM_W - 1);
            end

            ST_DIV: begin
                n_rem = w_ge ? w_rem_sub[TIME_W-1:0] : w_rem_sh[TIME_W-1:0];
                n_sat = r_sat | r_quo[RATE_W-1];
                n_quo = {r_quo[RATE_W-2:0], w_ge};
                n_num = {r_num[NUM_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end

            ST_FIN: begin
                if (w_rate != r_last_rate) begin
                    w_emit      = 1'b1;
                    n_res       = w_rate;
                    n_gap_run   = '0;
                    n_last_rate = w_rate;
                end
                n_win_start   = r_time;
                n_last_commit = r_time;
                n_commit_seen = 1'b1;
                n_frames      = '0;
                n_win_open    = 1'b0;
            end

            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EVAL;
            ST_EVAL: begin
                if (!r_enable)    n_state = ST_IDLE;
                else if (w_go_div) n_state = ST_MUL;
                else if (w_emit)   n_state = ST_EMIT;
                else               n_state = ST_IDLE;
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (r_cnt == '0) n_state = ST_FIN;
            ST_FIN:  n_state = w_emit ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs and output register
    // ---------------------------------------------------------------
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_rate  = r_out_rate;
        if ((r_state == ST_EMIT) && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_rate  = r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rate_value = r_out_rate;

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_win_start   <= '0;
            r_last_commit <= '0;
            r_commit_seen <= 1'b0;
            r_frames      <= '0;
            r_gap_run     <= '0;
            r_last_rate   <= '0;
            r_win_open    <= 1'b0;
            r_skip        <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_win_start   <= n_win_start;
            r_last_commit <= n_last_commit;
            r_commit_seen <= n_commit_seen;
            r_frames      <= n_frames;
            r_gap_run     <= n_gap_run;
            r_last_rate   <= n_last_rate;
            r_win_open    <= n_win_open;
            r_skip        <= n_skip;
            r_cnt         <= n_cnt;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_time     <= n_time;
        r_user     <= n_user;
        r_idle     <= n_idle;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_quo      <= n_quo;
        r_sat      <= n_sat;
        r_res      <= n_res;
        r_out_rate <= n_out_rate;
    end

endmodule

>>> design/frm_checker.sv
// Port-level checker for the frame rate monitor, bound to the top level.
`include "frame_rate_monitor_unit_assert.svh"

module frm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [frm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [frm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic [frm_pkg::TIME_W-1:0]      i_time_us,
    input logic                            i_user_input,
    input logic                            i_idle_mode,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [frm_pkg::RATE_W-1:0]      o_rate_value
);
    import frm_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && o_in_ready;

    // stalled report holds its value
    `FRM_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_rate_value)), "report dropped or changed while stalled")

    // one transaction in flight: busy right after acceptance
    `FRM_ASSERT(a_busy_after_acc, i_clk, i_rst_n, w_in_acc |=> !o_in_ready, "accepted a transaction while one is in flight")

    // no report can appear in the cycle right after acceptance
    `FRM_ASSERT(a_no_early_report, i_clk, i_rst_n, w_in_acc |=> !$rose(o_out_valid), "report appeared too early after acceptance")

    // reset empties the output and leaves the block ready
    `FRM_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset did not clear the block")

endmodule

bind frame_rate_monitor_unit frm_checker u_frm_checker (.*);
